/* rtl/lav_pkg.sv */
// Package for the look-at view matrix block: word types, widths and row codes.
// Used by lav_norm, lav_rows and the top level; depends on nothing.
`default_nettype none
package lav_pkg;

  localparam int W_W   = 32;
  localparam int D_W   = W_W + 1;
  localparam int FRAC  = 16;
  localparam int NRM_W = 30;
  localparam int SQ_W  = 2 * NRM_W + 2;
  localparam int N_W   = NRM_W + 1;
  localparam int QUO_W = FRAC + 1;
  localparam int R_W   = QUO_W + 1;
  localparam int C_W   = R_W + W_W + 1;
  localparam int VX_W  = 2 * R_W + 1;

  localparam logic [1:0] BASIS_U = 2'd0;
  localparam logic [1:0] BASIS_V = 2'd1;
  localparam logic [1:0] BASIS_W = 2'd2;

  typedef struct packed {
    logic                  mode;
    logic signed [W_W-1:0] pos_x;
    logic signed [W_W-1:0] pos_y;
    logic signed [W_W-1:0] pos_z;
    logic signed [W_W-1:0] vec_x;
    logic signed [W_W-1:0] vec_y;
    logic signed [W_W-1:0] vec_z;
    logic signed [W_W-1:0] up_x;
    logic signed [W_W-1:0] up_y;
    logic signed [W_W-1:0] up_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            basis;
    logic signed [W_W-1:0] comp_x;
    logic signed [W_W-1:0] comp_y;
    logic signed [W_W-1:0] comp_z;
    logic signed [W_W-1:0] offset;
    logic                  last;
    logic                  degenerate;
  } out_word_t;

endpackage
`default_nettype wire

/* rtl/lav_norm.sv */
// Pipelined vector normalizer: power-of-two prescale, square sum, bit-pair square
// root and restoring division, one step per stage. Depends on lav_pkg.
`default_nettype none
module lav_norm #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire logic [2:0][IN_W-1:0]              in_a,
  input  wire logic [SIDE_W-1:0]                 in_side,
  output logic                                   out_vld,
  output logic                                   out_zero,
  output logic [2:0][lav_pkg::R_W-1:0]           out_r,
  output logic [SIDE_W-1:0]                      out_side
);

  localparam int NG   = (IN_W + 7) / 8;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int OW   = NG * 8;
  localparam int PW   = GW + 3;
  localparam int MW   = lav_pkg::NRM_W;
  localparam int TOPB = MW - 1;
  localparam int SQW  = lav_pkg::SQ_W;
  localparam int NSQ  = SQW / 2 + 1;
  localparam int XW   = SQW + 2;
  localparam int NW   = lav_pkg::N_W;
  localparam int QW   = lav_pkg::QUO_W;
  localparam int RW   = lav_pkg::R_W;
  localparam int DW   = MW + lav_pkg::FRAC + 1;
  localparam int UW   = SIDE_W + 4;
  localparam int TW   = 3 * MW + UW;

  // stage 1: magnitudes
  logic                     vld1_r;
  logic [2:0][IN_W-1:0]     m1_r;
  logic [2:0]               neg1_r;
  logic [SIDE_W-1:0]        side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1_r[i]   <= in_a[i][IN_W-1] ? IN_W'(~in_a[i] + 1'b1) : in_a[i];
      neg1_r[i] <= in_a[i][IN_W-1];
    end
    side1_r <= in_side;
  end

  // stage 2: coarse leading-one group
  logic [OW-1:0]        or_c;
  logic [GW-1:0]        g_c;
  logic                 vld2_r;
  logic [2:0][IN_W-1:0] m2_r;
  logic [2:0]           neg2_r;
  logic [SIDE_W-1:0]    side2_r;
  logic [OW-1:0]        or2_r;
  logic [GW-1:0]        g2_r;

  always_comb begin
    or_c = OW'(m1_r[0] | m1_r[1] | m1_r[2]);
    g_c  = '0;
    for (int gi = 0; gi < NG; gi++) begin
      if (or_c[gi*8 +: 8] != 8'd0) begin
        g_c = GW'(gi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_r    <= m1_r;
    neg2_r  <= neg1_r;
    side2_r <= side1_r;
    or2_r   <= or_c;
    g2_r    <= g_c;
  end

  // stage 3: fine leading-one position
  logic [7:0]           byte_c;
  logic [2:0]           f_c;
  logic                 vld3_r;
  logic [2:0][IN_W-1:0] m3_r;
  logic [2:0]           neg3_r;
  logic [SIDE_W-1:0]    side3_r;
  logic                 zero3_r;
  logic [PW-1:0]        p3_r;

  always_comb begin
    byte_c = or2_r[{g2_r, 3'b000} +: 8];
    f_c    = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte_c[b]) begin
        f_c = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    m3_r    <= m2_r;
    neg3_r  <= neg2_r;
    side3_r <= side2_r;
    zero3_r <= (or2_r == '0);
    p3_r    <= {g2_r, f_c};
  end

  // stage 4: prescale so the largest magnitude has its top bit at TOPB
  logic [2:0][MW-1:0] mm_c;
  logic               vld4_r;
  logic [2:0][MW-1:0] mm4_r;
  logic [2:0]         neg4_r;
  logic [SIDE_W-1:0]  side4_r;
  logic               zero4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(p3_r) >= TOPB) begin
        mm_c[i] = MW'(m3_r[i] >> (int'(p3_r) - TOPB));
      end else begin
        mm_c[i] = MW'(m3_r[i] << (TOPB - int'(p3_r)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    mm4_r   <= mm_c;
    neg4_r  <= neg3_r;
    side4_r <= side3_r;
    zero4_r <= zero3_r;
  end

  // stage 5: squares
  logic                 vld5_r;
  logic [2:0][2*MW-1:0] sq5_r;
  logic [2:0][MW-1:0]   mm5_r;
  logic [2:0]           neg5_r;
  logic [SIDE_W-1:0]    side5_r;
  logic                 zero5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq5_r[i] <= mm4_r[i] * mm4_r[i];
    end
    mm5_r   <= mm4_r;
    neg5_r  <= neg4_r;
    side5_r <= side4_r;
    zero5_r <= zero4_r;
  end

  // stage 6 and square root stages
  logic          sv_r [0:NSQ];
  logic [XW-1:0] sx_r [0:NSQ];
  logic [XW-1:0] sr_r [0:NSQ];
  logic [TW-1:0] st_r [0:NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    sx_r[0] <= XW'(sq5_r[0]) + XW'(sq5_r[1]) + XW'(sq5_r[2]);
    sr_r[0] <= '0;
    st_r[0] <= {mm5_r, neg5_r, zero5_r, side5_r};
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    localparam logic [XW-1:0] BITV = {{(XW-1){1'b0}}, 1'b1} << (SQW - 2 * k);
    logic [XW-1:0] t_c;
    logic [XW-1:0] x_c;
    logic [XW-1:0] r_c;

    always_comb begin
      t_c = sr_r[k] + BITV;
      if (sx_r[k] >= t_c) begin
        x_c = sx_r[k] - t_c;
        r_c = (sr_r[k] >> 1) + BITV;
      end else begin
        x_c = sx_r[k];
        r_c = sr_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sx_r[k+1] <= x_c;
      sr_r[k+1] <= r_c;
      st_r[k+1] <= st_r[k];
    end
  end

  // numerator stage and division stages
  logic [NW-1:0]      n_c;
  logic [2:0][MW-1:0] mmq_c;
  logic               dv_r [0:QW];
  logic [2:0][DW-1:0] dr_r [0:QW];
  logic [NW-1:0]      dn_r [0:QW];
  logic [2:0][QW-1:0] dq_r [0:QW];
  logic [UW-1:0]      du_r [0:QW];

  assign n_c   = sr_r[NSQ][NW-1:0];
  assign mmq_c = st_r[NSQ][TW-1 -: 3*MW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= sv_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dr_r[0][i] <= DW'({mmq_c[i], {lav_pkg::FRAC{1'b0}}}) + DW'(n_c >> 1);
    end
    dn_r[0] <= n_c;
    dq_r[0] <= '0;
    du_r[0] <= st_r[NSQ][UW-1:0];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [DW-1:0]      dvs_c;
    logic [2:0][DW-1:0] rn_c;
    logic [2:0][QW-1:0] qn_c;

    always_comb begin
      dvs_c = DW'(dn_r[j]) << SH;
      for (int i = 0; i < 3; i++) begin
        rn_c[i] = dr_r[j][i];
        qn_c[i] = dq_r[j][i];
        if (dr_r[j][i] >= dvs_c) begin
          rn_c[i]     = dr_r[j][i] - dvs_c;
          qn_c[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dr_r[j+1] <= rn_c;
      dn_r[j+1] <= dn_r[j];
      dq_r[j+1] <= qn_c;
      du_r[j+1] <= du_r[j];
    end
  end

  logic [2:0] negq_c;
  assign negq_c   = du_r[QW][SIDE_W+3:SIDE_W+1];
  assign out_vld  = dv_r[QW];
  assign out_zero = du_r[QW][SIDE_W];
  assign out_side = du_r[QW][SIDE_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_r[i] = negq_c[i] ? RW'(-{1'b0, dq_r[QW][i]}) : {1'b0, dq_r[QW][i]};
    end
  end

endmodule
`default_nettype wire

/* rtl/lav_xprod.sv */
// Two-stage exact cross product a x b: registered products, registered differences.
// Depends on nothing outside this file.
`default_nettype none
module lav_xprod #(
  parameter int A_W    = 18,
  parameter int B_W    = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [2:0][A_W-1:0]         in_a,
  input  wire logic [2:0][B_W-1:0]         in_b,
  input  wire logic [SIDE_W-1:0]           in_side,
  output logic                             out_vld,
  output logic [2:0][A_W+B_W:0]            out_c,
  output logic [SIDE_W-1:0]                out_side
);

  localparam int PR_W = A_W + B_W;

  logic signed [PR_W-1:0] p_c [6];
  logic                   vld1_r;
  logic [5:0][PR_W-1:0]   p1_r;
  logic [SIDE_W-1:0]      side1_r;
  logic                   vld2_r;
  logic [2:0][PR_W:0]     c2_r;
  logic [SIDE_W-1:0]      side2_r;

  always_comb begin
    p_c[0] = $signed(in_a[1]) * $signed(in_b[2]);
    p_c[1] = $signed(in_a[2]) * $signed(in_b[1]);
    p_c[2] = $signed(in_a[2]) * $signed(in_b[0]);
    p_c[3] = $signed(in_a[0]) * $signed(in_b[2]);
    p_c[4] = $signed(in_a[0]) * $signed(in_b[1]);
    p_c[5] = $signed(in_a[1]) * $signed(in_b[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      p1_r[i] <= p_c[i];
    end
    side1_r <= in_side;
    for (int i = 0; i < 3; i++) begin
      c2_r[i] <= {p1_r[2*i][PR_W-1], p1_r[2*i]} - {p1_r[2*i+1][PR_W-1], p1_r[2*i+1]};
    end
    side2_r <= side1_r;
  end

  assign out_vld  = vld2_r;
  assign out_c    = c2_r;
  assign out_side = side2_r;

endmodule
`default_nettype wire

/* rtl/lav_rows.sv */
// Row finisher: rounds v, forms dot-product offsets with saturation, and sends the
// three rows out one per cycle. Depends on lav_pkg.
`default_nettype none
module lav_rows (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_vld,
  input  wire logic                                in_ok,
  input  wire logic [2:0][lav_pkg::R_W-1:0]        in_w,
  input  wire logic [2:0][lav_pkg::R_W-1:0]        in_u,
  input  wire logic [2:0][lav_pkg::VX_W-1:0]       in_vx,
  input  wire logic [2:0][lav_pkg::W_W-1:0]        in_pos,
  output logic                                     out_valid,
  output lav_pkg::out_word_t                       out_word
);

  localparam int FR   = lav_pkg::FRAC;
  localparam int WW   = lav_pkg::W_W;
  localparam int RW   = lav_pkg::R_W;
  localparam int VXW  = lav_pkg::VX_W;
  localparam int VMW  = VXW + 1 - FR;
  localparam int CW   = VMW + 1;
  localparam int PRW  = CW + WW;
  localparam int SMW  = PRW + 2;
  localparam int OMW  = SMW + 1 - FR;
  localparam logic [OMW-1:0] POS_MAX = OMW'(33'h07fffffff);
  localparam logic [OMW-1:0] NEG_MAX = OMW'(33'h080000000);

  // R1: magnitude and rounding of v
  logic                  vld1_r;
  logic [2:0][VMW-1:0]   vm1_r;
  logic [2:0]            vn1_r;
  logic [2:0][RW-1:0]    w1_r;
  logic [2:0][RW-1:0]    u1_r;
  logic [2:0][WW-1:0]    pos1_r;
  logic                  ok1_r;

  // R2: signed rows u, v, w
  logic                   vld2_r;
  logic [2:0][2:0][CW-1:0] rw2_r;
  logic [2:0][WW-1:0]     pos2_r;
  logic                   ok2_r;

  // R3: products
  logic                     vld3_r;
  logic [2:0][2:0][PRW-1:0] pr3_r;
  logic [2:0][2:0][CW-1:0]  rw3_r;
  logic                     ok3_r;

  // R4: dot sums
  logic                    vld4_r;
  logic [2:0][SMW-1:0]     sm4_r;
  logic [2:0][2:0][CW-1:0] rw4_r;
  logic                    ok4_r;

  // R5: rounded dot magnitudes
  logic                    vld5_r;
  logic [2:0][OMW-1:0]     om5_r;
  logic [2:0]              on5_r;
  logic [2:0][2:0][CW-1:0] rw5_r;
  logic                    ok5_r;

  logic [2:0][VXW-1:0]   vmag_c;
  logic [2:0][SMW-1:0]   smag_c;
  lav_pkg::out_word_t [2:0] word_c;
  lav_pkg::out_word_t [2:0] hold_r;
  lav_pkg::out_word_t    ow_r;
  logic                  ov_r;
  logic [1:0]            ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag_c[i] = in_vx[i][VXW-1] ? VXW'(-in_vx[i]) : in_vx[i];
      smag_c[i] = sm4_r[i][SMW-1] ? SMW'(-sm4_r[i]) : sm4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vm1_r[i] <= VMW'(((VXW+1)'(vmag_c[i]) + (VXW+1)'(1 << (FR - 1))) >> FR);
      vn1_r[i] <= in_vx[i][VXW-1];
    end
    w1_r   <= in_w;
    u1_r   <= in_u;
    pos1_r <= in_pos;
    ok1_r  <= in_ok;

    for (int i = 0; i < 3; i++) begin
      rw2_r[0][i] <= CW'($signed(u1_r[i]));
      rw2_r[1][i] <= vn1_r[i] ? CW'(-{1'b0, vm1_r[i]}) : {1'b0, vm1_r[i]};
      rw2_r[2][i] <= CW'($signed(w1_r[i]));
    end
    pos2_r <= pos1_r;
    ok2_r  <= ok1_r;

    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pr3_r[k][i] <= PRW'($signed(PRW'($signed(rw2_r[k][i]))) *
                            $signed(PRW'($signed(pos2_r[i]))));
      end
    end
    rw3_r <= rw2_r;
    ok3_r <= ok2_r;

    for (int k = 0; k < 3; k++) begin
      sm4_r[k] <= SMW'($signed(pr3_r[k][0])) + SMW'($signed(pr3_r[k][1])) +
                  SMW'($signed(pr3_r[k][2]));
    end
    rw4_r <= rw3_r;
    ok4_r <= ok3_r;

    for (int k = 0; k < 3; k++) begin
      om5_r[k] <= OMW'(((SMW+1)'(smag_c[k]) + (SMW+1)'(1 << (FR - 1))) >> FR);
      on5_r[k] <= sm4_r[k][SMW-1];
    end
    rw5_r <= rw4_r;
    ok5_r <= ok4_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      word_c[k].basis      = 2'(k);
      word_c[k].last       = (2'(k) == lav_pkg::BASIS_W);
      word_c[k].degenerate = !ok5_r;
      word_c[k].comp_x     = '0;
      word_c[k].comp_y     = '0;
      word_c[k].comp_z     = '0;
      word_c[k].offset     = '0;
      if (ok5_r) begin
        word_c[k].comp_x = WW'($signed(rw5_r[k][0]));
        word_c[k].comp_y = WW'($signed(rw5_r[k][1]));
        word_c[k].comp_z = WW'($signed(rw5_r[k][2]));
        if (on5_r[k]) begin
          word_c[k].offset = (om5_r[k] > POS_MAX) ? POS_MAX[WW-1:0] : om5_r[k][WW-1:0];
        end else begin
          word_c[k].offset = (om5_r[k] > NEG_MAX) ? NEG_MAX[WW-1:0]
                                                  : WW'(-om5_r[k][WW-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      ph_r <= lav_pkg::BASIS_U;
    end else if (vld5_r) begin
      ov_r <= 1'b1;
      ph_r <= lav_pkg::BASIS_V;
    end else if (ph_r != lav_pkg::BASIS_U) begin
      ov_r <= 1'b1;
      ph_r <= (ph_r == lav_pkg::BASIS_W) ? lav_pkg::BASIS_U : ph_r + 2'd1;
    end else begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld5_r) begin
      ow_r   <= word_c[0];
      hold_r <= word_c;
    end else if (ph_r != lav_pkg::BASIS_U) begin
      ow_r <= hold_r[ph_r];
    end
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule
`default_nettype wire

/* rtl/look_at_view_matrix_top.sv */
// Top level of the look-at view matrix block: input capture, two normalizers, two
// cross products and the row finisher. Depends on lav_pkg and all lav_* modules.
//
// Usage:
//   Drive in_word and raise start; the word is taken at a rising edge where start
//   is high and busy is low. busy then rises and stays high until the counter
//   cnt_r has run down to zero; no word is taken while busy is high.
//   Each word yields three rows on out_word, u then v then w, one per cycle, each
//   marked by out_valid for exactly one cycle; last is set on the w row.
//   The first row passes, after the input register, through two normalizers of
//   56 stages each (prescale, square sum, one square-root step per stage, one
//   quotient bit per stage), two cross products and the row finisher.
//   Words overlap in the pipeline; busy keeps the rows of successive words apart.
//   A zero direction, or a zero w x up, gives zero rows with degenerate set.
//   The receiver cannot stall; rows are presented once and not held.
//   Synchronous reset clears all valid bits and the output sequencer; words in
//   flight are dropped.
`default_nettype none
module look_at_view_matrix_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lav_pkg::in_word_t   in_word,
  output logic                     out_valid,
  output lav_pkg::out_word_t       out_word
);

  localparam int WW   = lav_pkg::W_W;
  localparam int DW   = lav_pkg::D_W;
  localparam int RW   = lav_pkg::R_W;
  localparam int CW   = lav_pkg::C_W;
  localparam int VXW  = lav_pkg::VX_W;
  localparam int S1_W = 6 * WW;
  localparam int S2_W = 3 * WW + 3 * RW + 1;
  localparam int S3_W = 3 * WW + 6 * RW + 1;

  logic                 accept_c;
  logic [1:0]           cnt_r;
  logic [2:0][WW-1:0]   pos_c;
  logic [2:0][WW-1:0]   vec_c;
  logic [2:0][WW-1:0]   up_c;
  logic                 vld0_r;
  logic [2:0][DW-1:0]   d0_r;
  logic [2:0][WW-1:0]   pos0_r;
  logic [2:0][WW-1:0]   up0_r;

  assign accept_c = start && !busy;
  assign busy     = (cnt_r != 2'd0);
  assign pos_c    = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
  assign vec_c    = {in_word.vec_z, in_word.vec_y, in_word.vec_x};
  assign up_c     = {in_word.up_z, in_word.up_y, in_word.up_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept_c;
      if (accept_c) begin
        cnt_r <= 2'd2;
      end else if (cnt_r != 2'd0) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_c) begin
      for (int i = 0; i < 3; i++) begin
        if (in_word.mode) begin
          d0_r[i] <= DW'($signed(vec_c[i])) - DW'($signed(pos_c[i]));
        end else begin
          d0_r[i] <= DW'($signed(vec_c[i]));
        end
      end
      pos0_r <= pos_c;
      up0_r  <= up_c;
    end
  end

  logic                 n1_vld;
  logic                 n1_zero;
  logic [2:0][RW-1:0]   n1_w;
  logic [S1_W-1:0]      n1_side;

  lav_norm #(
    .IN_W   (DW),
    .SIDE_W (S1_W)
  ) u_norm_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld0_r),
    .in_a     (d0_r),
    .in_side  ({pos0_r, up0_r}),
    .out_vld  (n1_vld),
    .out_zero (n1_zero),
    .out_r    (n1_w),
    .out_side (n1_side)
  );

  logic                 x1_vld;
  logic [2:0][CW-1:0]   x1_c;
  logic [S2_W-1:0]      x1_side;

  lav_xprod #(
    .A_W    (RW),
    .B_W    (WW),
    .SIDE_W (S2_W)
  ) u_xprod_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (n1_vld),
    .in_a     (n1_w),
    .in_b     (n1_side[3*WW-1:0]),
    .in_side  ({n1_side[S1_W-1 -: 3*WW], n1_w, n1_zero}),
    .out_vld  (x1_vld),
    .out_c    (x1_c),
    .out_side (x1_side)
  );

  logic                 n2_vld;
  logic                 n2_zero;
  logic [2:0][RW-1:0]   n2_u;
  logic [S2_W-1:0]      n2_side;

  lav_norm #(
    .IN_W   (CW),
    .SIDE_W (S2_W)
  ) u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (x1_vld),
    .in_a     (x1_c),
    .in_side  (x1_side),
    .out_vld  (n2_vld),
    .out_zero (n2_zero),
    .out_r    (n2_u),
    .out_side (n2_side)
  );

  logic                 ok2_c;
  logic [2:0][RW-1:0]   w2_c;
  logic                 x2_vld;
  logic [2:0][VXW-1:0]  x2_v;
  logic [S3_W-1:0]      x2_side;

  assign ok2_c = !n2_zero && !n2_side[0];
  assign w2_c  = n2_side[3*RW:1];

  lav_xprod #(
    .A_W    (RW),
    .B_W    (RW),
    .SIDE_W (S3_W)
  ) u_xprod_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (n2_vld),
    .in_a     (w2_c),
    .in_b     (n2_u),
    .in_side  ({n2_side[S2_W-1 -: 3*WW], w2_c, n2_u, ok2_c}),
    .out_vld  (x2_vld),
    .out_c    (x2_v),
    .out_side (x2_side)
  );

  lav_rows u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (x2_vld),
    .in_ok     (x2_side[0]),
    .in_w      (x2_side[6*RW:3*RW+1]),
    .in_u      (x2_side[3*RW:1]),
    .in_vx     (x2_v),
    .in_pos    (x2_side[S3_W-1 -: 3*WW]),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a word was taken");

  a_u_then_v: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.basis == lav_pkg::BASIS_U) |=>
      (out_valid && out_word.basis == lav_pkg::BASIS_V))
    else $error("v row did not follow u row");

  a_v_then_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.basis == lav_pkg::BASIS_V) |=>
      (out_valid && out_word.basis == lav_pkg::BASIS_W && out_word.last))
    else $error("w row did not follow v row");

  a_last_on_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last == (out_word.basis == lav_pkg::BASIS_W)))
    else $error("last flag on wrong row");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.degenerate) |->
      (out_word.comp_x == '0 && out_word.comp_y == '0 &&
       out_word.comp_z == '0 && out_word.offset == '0))
    else $error("degenerate row is not zero");

endmodule
`default_nettype wire

/* dv/look_at_view_matrix_check.sv */
// Checker for the look-at view matrix block: watches accepted input words,
// predicts the three basis rows of each and compares the output rows. Needs lav_pkg.
`default_nettype none
module look_at_view_matrix_check (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire lav_pkg::in_word_t  in_word,
  input  wire logic               out_valid,
  input  wire lav_pkg::out_word_t out_word,
  output int                      fail_count,
  output int                      rows_pending
);

  lav_pkg::out_word_t row_queue[$];

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    abs64 = x < 0 ? -x : x;
  endfunction

  function automatic logic signed [63:0] round_shr16(input logic signed [63:0] x);
    logic [63:0] m;
    m = abs64(x);
    m = (m + 64'd32768) >> 16;
    round_shr16 = x < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    int_sqrt = res;
  endfunction

  function automatic logic unit_vec(input logic signed [63:0] a[3],
                                    output logic signed [63:0] r[3]);
    logic [63:0] m[3];
    logic [63:0] top, sum, n, q;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(a[i]);
      if (m[i] > top) top = m[i];
    end
    for (int i = 0; i < 3; i++) r[i] = 0;
    if (top == 0) return 1'b0;
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 16) + n / 2) / n;
      r[i] = a[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1'b1;
  endfunction

  task automatic predict_rows(input lav_pkg::in_word_t w_in);
    logic signed [63:0] p[3], d[3], up[3], c[3], fw[3], sd[3], uv[3];
    logic signed [63:0] dot, off;
    logic ok;
    lav_pkg::out_word_t r;
    p[0] = w_in.pos_x; p[1] = w_in.pos_y; p[2] = w_in.pos_z;
    d[0] = w_in.vec_x; d[1] = w_in.vec_y; d[2] = w_in.vec_z;
    up[0] = w_in.up_x; up[1] = w_in.up_y; up[2] = w_in.up_z;
    if (w_in.mode) for (int i = 0; i < 3; i++) d[i] = d[i] - p[i];
    for (int i = 0; i < 3; i++) begin
      sd[i] = 0;
      uv[i] = 0;
    end
    ok = unit_vec(d, fw);
    if (ok) begin
      c[0] = fw[1] * up[2] - fw[2] * up[1];
      c[1] = fw[2] * up[0] - fw[0] * up[2];
      c[2] = fw[0] * up[1] - fw[1] * up[0];
      ok = unit_vec(c, sd);
    end
    if (ok) begin
      uv[0] = round_shr16(fw[1] * sd[2] - fw[2] * sd[1]);
      uv[1] = round_shr16(fw[2] * sd[0] - fw[0] * sd[2]);
      uv[2] = round_shr16(fw[0] * sd[1] - fw[1] * sd[0]);
    end
    for (int k = 0; k < 3; k++) begin
      logic signed [63:0] b[3];
      for (int i = 0; i < 3; i++) b[i] = k == 0 ? sd[i] : (k == 1 ? uv[i] : fw[i]);
      off = 0;
      if (ok) begin
        dot = b[0] * p[0] + b[1] * p[1] + b[2] * p[2];
        off = -round_shr16(dot);
        if (off > 64'sd2147483647) off = 64'sd2147483647;
        if (off < -64'sd2147483648) off = -64'sd2147483648;
      end
      r.basis = k == 0 ? lav_pkg::BASIS_U : (k == 1 ? lav_pkg::BASIS_V : lav_pkg::BASIS_W);
      r.comp_x = ok ? b[0][31:0] : '0;
      r.comp_y = ok ? b[1][31:0] : '0;
      r.comp_z = ok ? b[2][31:0] : '0;
      r.offset = off[31:0];
      r.last = k == 2;
      r.degenerate = !ok;
      row_queue.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) predict_rows(in_word);
      if (out_valid) begin
        if (row_queue.size() == 0) begin
          $error("row with no expectation: %p", out_word);
          fail_count <= fail_count + 1;
        end else begin
          lav_pkg::out_word_t e;
          int bad;
          e = row_queue.pop_front();
          bad = 0;
          if (out_word.basis !== e.basis) begin
            $error("basis exp %0d got %0d", e.basis, out_word.basis); bad++;
          end
          if (out_word.comp_x !== e.comp_x) begin
            $error("comp_x exp %0d got %0d", e.comp_x, out_word.comp_x); bad++;
          end
          if (out_word.comp_y !== e.comp_y) begin
            $error("comp_y exp %0d got %0d", e.comp_y, out_word.comp_y); bad++;
          end
          if (out_word.comp_z !== e.comp_z) begin
            $error("comp_z exp %0d got %0d", e.comp_z, out_word.comp_z); bad++;
          end
          if (out_word.offset !== e.offset) begin
            $error("offset exp %0d got %0d", e.offset, out_word.offset); bad++;
          end
          if (out_word.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_word.last); bad++;
          end
          if (out_word.degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, out_word.degenerate); bad++;
          end
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
    end
    rows_pending = row_queue.size();
  end
endmodule
`default_nettype wire

/* dv/look_at_view_matrix_top_test.sv */
// Testbench top for the look-at view matrix block: directed and random words
// with random gaps, verdict from the checker. Needs lav_pkg and the checker.
`default_nettype none
module look_at_view_matrix_top_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lav_pkg::in_word_t in_word = '0;
  logic out_valid;
  lav_pkg::out_word_t out_word;
  int fail_count;
  int rows_pending;

  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  look_at_view_matrix_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  look_at_view_matrix_check checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .fail_count(fail_count), .rows_pending(rows_pending)
  );

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = $urandom;
      1: rand_coord = MAXV;
      2: rand_coord = MINV;
      3: rand_coord = $signed($urandom_range(0, 16)) - 8;
      default: rand_coord = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  task automatic send_word(input lav_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      in_word <= '0;
      repeat (gap) @(negedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_vecs(input logic m, input logic signed [31:0] px, py, pz,
                           vx, vy, vz, ux, uy, uz);
    lav_pkg::in_word_t w;
    w = '{m, px, py, pz, vx, vy, vz, ux, uy, uz};
    send_word(w);
  endtask

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    lav_pkg::in_word_t w;
    int t;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_vecs(1'b0, 0, 0, 0, 0, 0, -ONE, 0, ONE, 0);
    send_vecs(1'b0, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0);
    send_vecs(1'b0, 0, 0, 0, 0, ONE, 0, 0, ONE, 0);
    send_vecs(1'b0, 0, 0, 0, 0, 0, ONE, 0, 0, 0);
    send_vecs(1'b1, ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0);
    send_vecs(1'b1, MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0);
    send_vecs(1'b1, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, 0);
    send_vecs(1'b0, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV);
    send_vecs(1'b0, MINV, MINV, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV);
    send_vecs(1'b0, MAXV, MAXV, MAXV, 1, 0, 0, 0, 0, 1);
    send_vecs(1'b1, 5, 7, -3, 5, 7, -2, 1, 0, 0);
    send_vecs(1'b0, -ONE, 0, ONE, 0, -2 * ONE, 0, 0, 3 * ONE, 0);
    send_vecs(1'b1, 0, 0, 0, ONE, 0, 0, MINV, 0, 0);
    send_vecs(1'b0, -1, -1, -1, -1, -1, -1, 1, -1, 1);
    start <= 1'b0;
    in_word <= '0;
    while (rows_pending != 0) @(negedge clk);
    for (int n = 0; n < 296; n++) begin
      for (int b = 0; b + 32 <= $bits(lav_pkg::in_word_t); b += 32) w[b +: 32] = $urandom;
      w.mode = 1'($urandom_range(0, 1));
      t = $urandom_range(0, 9);
      if (t < 3) begin
        w.pos_x = rand_coord(); w.pos_y = rand_coord(); w.pos_z = rand_coord();
        w.vec_x = rand_coord(); w.vec_y = rand_coord(); w.vec_z = rand_coord();
        w.up_x = rand_coord(); w.up_y = rand_coord(); w.up_z = rand_coord();
      end else if (t == 3) begin
        w.up_x = w.vec_x; w.up_y = w.vec_y; w.up_z = w.vec_z;
        w.mode = 1'b0;
      end else if (t == 4) begin
        w.mode = 1'b1;
        w.vec_x = w.pos_x; w.vec_y = w.pos_y; w.vec_z = w.pos_z;
      end else if (t == 5) begin
        w.up_x = 0; w.up_y = 0; w.up_z = 0;
      end
      if (n == 150) begin
        start <= 1'b0;
        in_word <= '0;
        while (rows_pending != 0) @(negedge clk);
      end
      send_word(w);
    end
    start <= 1'b0;
    in_word <= '0;
    while (rows_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/lav_xprod.sv
rtl/lav_rows.sv
rtl/look_at_view_matrix_top.sv
dv/look_at_view_matrix_check.sv
dv/look_at_view_matrix_top_test.sv
